// ----- src/shared_page_slot_allocator_assert.svh -----
// Assertion macros for the shared page slot allocator.
// Used by shared_page_slot_allocator.sv; expects clk_i and rst_ni in scope.
`ifndef SHARED_PAGE_SLOT_ALLOCATOR_ASSERT_SVH
`define SHARED_PAGE_SLOT_ALLOCATOR_ASSERT_SVH

// Property checked on every clock edge outside reset.
`define SPA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("spa assertion failed");

// Antecedent holds in one cycle, consequent must hold in the next.
`define SPA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("spa assertion failed");

`endif

// ----- src/spa_pkg.sv -----
// Shared types and constants of the shared page slot allocator.
// No dependencies; imported by spa_cell and shared_page_slot_allocator.
`default_nettype none

package spa_pkg;

  // Fixed field widths
  localparam int unsigned ADDR_W = 32;
  localparam int unsigned APB_AW = 2;

  // In-use bits held by one cell of the search chain
  localparam int unsigned CELL_SLOTS = 32;

  // Parameter defaults
  localparam int unsigned DEF_NUM_SLOTS  = 256;
  localparam int unsigned DEF_PAGE_BYTES = 4096;

  // Register byte addresses
  localparam logic [APB_AW-1:0] REG_ADDR_WINDOW_BASE = 2'd0;

  typedef enum logic {
    OP_ATTACH = 1'b0,
    OP_DETACH = 1'b1
  } spa_op_e;

  typedef enum logic [2:0] {
    ST_NEW       = 3'd0,
    ST_REUSED    = 3'd1,
    ST_EXHAUSTED = 3'd2,
    ST_DETACHED  = 3'd3,
    ST_NO_MATCH  = 3'd4
  } spa_status_e;

  typedef struct packed {
    spa_op_e           opcode;
    logic [ADDR_W-1:0] address;
  } spa_cmd_t;

  typedef struct packed {
    logic [ADDR_W-1:0] page_address;
    spa_status_e       status;
  } spa_result_t;

  // Control handed from cell to cell
  typedef struct packed {
    logic token;  // search still looking for a free slot
    logic found;  // a slot was claimed upstream, index rides alongside
  } spa_link_t;

endpackage

`default_nettype wire

// ----- src/spa_cell.sv -----
// One cell of the free-slot search chain: holds CELL_SLOTS in-use bits.
// Depends on spa_pkg.
`default_nettype none

module spa_cell #(
  parameter int unsigned BASE       = 0,
  parameter int unsigned VALID_BITS = 32,
  parameter int unsigned IDX_W      = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  spa_pkg::spa_link_t  link_i,
  input  logic [IDX_W-1:0]    link_idx_i,
  output spa_pkg::spa_link_t  link_o,
  output logic [IDX_W-1:0]    link_idx_o,
  input  logic [IDX_W-1:0]    tgt_idx_i,
  input  logic                clr_i,
  output logic                hit_o
);
  import spa_pkg::*;

  localparam int unsigned LOC_W = $clog2(CELL_SLOTS);
  localparam logic [CELL_SLOTS-1:0] MASK = (VALID_BITS >= CELL_SLOTS) ? '1 :
      CELL_SLOTS'((64'(1) << VALID_BITS) - 64'(1));

  logic [CELL_SLOTS-1:0] used_q, used_d;
  logic [CELL_SLOTS-1:0] free, lowest;
  logic [LOC_W-1:0]      tgt_loc, free_loc;
  logic                  tgt_match, has_free, claim;
  spa_link_t             link_q, link_d;
  logic [IDX_W-1:0]      idx_q, idx_d;

  // Broadcast target: does it fall in this cell
  assign tgt_match = (32'(tgt_idx_i) >= 32'(BASE)) &&
                     (32'(tgt_idx_i) < 32'(BASE + VALID_BITS));
  assign tgt_loc   = LOC_W'(32'(tgt_idx_i) - 32'(BASE));
  assign hit_o     = tgt_match & used_q[tgt_loc];

  // Lowest free bit, isolated then encoded
  assign free     = ~used_q & MASK;
  assign has_free = |free;
  assign lowest   = free & (~free + CELL_SLOTS'(1));

  always_comb begin
    free_loc = '0;
    for (int i = 0; i < CELL_SLOTS; i++) begin
      if (lowest[i]) begin
        free_loc = free_loc | LOC_W'(i);
      end
    end
  end

  assign claim = link_i.token & has_free;

  // In-use update: claim on token, clear on detach
  always_comb begin
    used_d = used_q;
    if (claim) begin
      used_d = used_d | lowest;
    end
    if (clr_i && tgt_match) begin
      used_d[tgt_loc] = 1'b0;
    end
  end

  // Link to next cell
  always_comb begin
    link_d.token = link_i.token & ~has_free;
    link_d.found = link_i.found | claim;
    idx_d        = claim ? IDX_W'(32'(BASE) + 32'(free_loc)) : link_idx_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
      link_q <= '0;
    end else begin
      used_q <= used_d;
      link_q <= link_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
  end

  assign link_o     = link_q;
  assign link_idx_o = idx_q;

endmodule

`default_nettype wire

// ----- src/shared_page_slot_allocator.sv -----
// Shared page slot allocator, top level: APB register, control, cell chain.
// Depends on spa_pkg, spa_cell and shared_page_slot_allocator_assert.svh.
// Reused-hint attach and detach give their result from the EVAL state;
// a new-slot attach goes on to WALK, where the search token walks the
// cell chain one cell per cycle.
// One transaction at a time; busy drops with the result strobe, which the
// receiver cannot stall. Reset clears every in-use bit and window_base.
`default_nettype none

module shared_page_slot_allocator #(
  parameter int unsigned NUM_SLOTS  = spa_pkg::DEF_NUM_SLOTS,
  parameter int unsigned PAGE_BYTES = spa_pkg::DEF_PAGE_BYTES
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // command channel
  input  logic                        start,
  output logic                        busy,
  input  spa_pkg::spa_cmd_t           cmd_i,
  output logic                        result_valid_o,
  output spa_pkg::spa_result_t        result_o,
  // configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [spa_pkg::APB_AW-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import spa_pkg::*;

  `include "shared_page_slot_allocator_assert.svh"

  localparam int unsigned IDX_W      = $clog2(NUM_SLOTS);
  localparam int unsigned PAGE_SHIFT = $clog2(PAGE_BYTES);
  localparam int unsigned NUM_CELLS  = (NUM_SLOTS + CELL_SLOTS - 1) / CELL_SLOTS;
  localparam logic [ADDR_W-1:0] SPAN = ADDR_W'((NUM_SLOTS - 1) * PAGE_BYTES);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EVAL = 3'b010,
    S_WALK = 3'b100
  } spa_state_e;

  spa_state_e        state_q, state_d;
  logic [ADDR_W-1:0] window_base_q;
  spa_op_e           op_q;
  logic [ADDR_W-1:0] addr_q, offset_q;
  spa_result_t       result_q, result_d;
  logic              result_valid_q, result_valid_d;

  logic              in_window, aligned, hint_ok, hit, launch, clr, walk_done;
  logic [IDX_W-1:0]  tgt_idx, addr_idx;
  logic [ADDR_W-1:0] slot_addr;
  logic [NUM_CELLS-1:0] hit_vec;

  spa_link_t         link [NUM_CELLS+1];
  logic [IDX_W-1:0]  link_idx [NUM_CELLS+1];

  // APB register: window_base
  assign pready = 1'b1;
  assign prdata = (paddr == REG_ADDR_WINDOW_BASE) ? window_base_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_base_q <= '0;
    end else if (psel && penable && pwrite && pready && paddr == REG_ADDR_WINDOW_BASE) begin
      window_base_q <= pwdata;
    end
  end

  // Command capture; offset into window is registered
  assign busy = (state_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q     <= OP_ATTACH;
      addr_q   <= '0;
      offset_q <= '0;
    end else if (start && !busy) begin
      op_q     <= cmd_i.opcode;
      addr_q   <= cmd_i.address;
      offset_q <= cmd_i.address - window_base_q;
    end
  end

  // Window decode
  assign in_window = (offset_q <= SPAN);
  assign aligned   = (offset_q[PAGE_SHIFT-1:0] == '0);
  assign tgt_idx   = IDX_W'(offset_q >> PAGE_SHIFT);
  assign hint_ok   = (addr_q != '0) && in_window;
  assign hit       = |hit_vec;

  assign launch    = (state_q == S_EVAL) && (op_q == OP_ATTACH) && !(hint_ok && hit);
  assign clr       = (state_q == S_EVAL) && (op_q == OP_DETACH) && in_window && aligned;
  assign walk_done = (state_q == S_WALK) && (link[NUM_CELLS].token || link[NUM_CELLS].found);

  // Slot page address
  assign addr_idx  = (state_q == S_WALK) ? link_idx[NUM_CELLS] : tgt_idx;
  assign slot_addr = window_base_q + (ADDR_W'(addr_idx) << PAGE_SHIFT);

  // Cell chain
  assign link[0].token = launch;
  assign link[0].found = 1'b0;
  assign link_idx[0]   = '0;

  for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
    localparam int unsigned CB = g * CELL_SLOTS;
    localparam int unsigned CV = (NUM_SLOTS - CB > CELL_SLOTS) ? CELL_SLOTS : NUM_SLOTS - CB;

    spa_cell #(
      .BASE       (CB),
      .VALID_BITS (CV),
      .IDX_W      (IDX_W)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .link_i     (link[g]),
      .link_idx_i (link_idx[g]),
      .link_o     (link[g+1]),
      .link_idx_o (link_idx[g+1]),
      .tgt_idx_i  (tgt_idx),
      .clr_i      (clr),
      .hit_o      (hit_vec[g])
    );
  end

  // Control sequencer
  always_comb begin
    state_d        = state_q;
    result_d       = result_q;
    result_valid_d = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        if (op_q == OP_DETACH) begin
          result_d.page_address = '0;
          result_d.status       = (in_window && aligned) ? ST_DETACHED : ST_NO_MATCH;
          result_valid_d        = 1'b1;
          state_d               = S_IDLE;
        end else if (hint_ok && hit) begin
          result_d.page_address = slot_addr;
          result_d.status       = ST_REUSED;
          result_valid_d        = 1'b1;
          state_d               = S_IDLE;
        end else begin
          state_d = S_WALK;
        end
      end
      S_WALK: begin
        if (walk_done) begin
          if (link[NUM_CELLS].found) begin
            result_d.page_address = slot_addr;
            result_d.status       = ST_NEW;
          end else begin
            result_d.page_address = '0;
            result_d.status       = ST_EXHAUSTED;
          end
          result_valid_d = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      result_valid_q <= 1'b0;
    end else begin
      state_q        <= state_d;
      result_valid_q <= result_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    result_q <= result_d;
  end

  assign result_valid_o = result_valid_q;
  assign result_o       = result_q;

  // Checks
  `SPA_ASSERT(a_result_after_busy, result_valid_o |-> $past(busy))
  `SPA_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  `SPA_ASSERT(a_hit_onehot, $onehot0(hit_vec))
  `SPA_ASSERT(a_exhausted_zero, result_valid_o && result_o.status == ST_EXHAUSTED |-> result_o.page_address == '0)

endmodule

`default_nettype wire
